// File: src/mm3_pkg.sv
// ============================================================================
// mm3_pkg
// Shared types, constants and helpers for the streaming MurmurHash3 x64_128
// hasher.
// ============================================================================
package mm3_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_ABSORB  = 2'd0;
    localparam logic [1:0] KIND_FINISH  = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Mixing constants of the hash.
    localparam logic [63:0] MIX_C1      = 64'h87C3_7B91_1142_53D5;
    localparam logic [63:0] MIX_C2      = 64'h4CF5_AD43_2745_937F;
    localparam logic [63:0] ROUND_ADD_A = 64'h0000_0000_52DC_E729;
    localparam logic [63:0] ROUND_ADD_B = 64'h0000_0000_3849_5AB5;
    localparam logic [63:0] FIN_MUL_A   = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] FIN_MUL_B   = 64'hC4CE_B9FE_1A85_EC53;

    localparam int BLOCK_BYTES = 16;
    localparam int IDX_W       = 4;

    // Write beat into the pending byte store.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } t_pend_wr;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BA_M1, ST_BA_M2, ST_BA_U1, ST_BA_U2,
        ST_BB_M1, ST_BB_M2, ST_BB_U1, ST_BB_U2,
        ST_TB_M1, ST_TB_M2,
        ST_TA_M1, ST_TA_M2,
        ST_FX, ST_FY,
        ST_F1_M1, ST_F1_M2,
        ST_F2_M1, ST_F2_M2,
        ST_FZ, ST_FW
    } t_state;

    // Rotate left by a constant amount in 1..63.
    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

    // One xor-shift step of the finalizer.
    function automatic logic [63:0] xsh33(input logic [63:0] x);
        xsh33 = x ^ (x >> 33);
    endfunction

endpackage

// File: src/mm3_mul.sv
// ============================================================================
// mm3_mul
// Shared 64 x 64 multiplier that keeps the low 64 bits of the product. It
// uses one 32 x 32 multiplier for the partial products in turn.
// ============================================================================
module mm3_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);

    logic        r_busy;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_res;
    logic        r_done;

    logic [31:0] op_x;
    logic [31:0] op_y;

    // The low product first, then the two cross products whose low halves
    // land in the upper word of the result.
    always_comb begin
        op_x = (r_step == 2'd2) ? r_a[63:32] : r_a[31:0];
        op_y = (r_step == 2'd1) ? r_b[63:32] : r_b[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_step <= 2'd0;
                end
            end else begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_start) begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= 64'd0;
            end
        end else begin
            r_prod <= op_x * op_y;
            unique case (r_step)
                2'd0: r_acc <= 64'd0;
                2'd1: r_acc <= r_prod;
                2'd2: r_acc <= r_acc + {r_prod[31:0], 32'd0};
                2'd3: r_res <= r_acc + {r_prod[31:0], 32'd0};
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_res;

endmodule

// File: src/mm3_pend.sv
// ============================================================================
// mm3_pend
// Pending byte store for the unfinished 16-byte block, with little-endian
// word loads for a full block and for a partial tail.
// ============================================================================
module mm3_pend (
    input  logic                    i_clk,
    input  mm3_pkg::t_pend_wr       i_wr,
    input  logic [mm3_pkg::IDX_W-1:0] i_count,
    output logic [63:0]             o_blk_w1,
    output logic [63:0]             o_blk_w2,
    output logic [63:0]             o_tail_w1,
    output logic [63:0]             o_tail_w2
);

    logic [7:0] r_bytes [mm3_pkg::BLOCK_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_bytes[i_wr.idx] <= i_wr.data;
        end
    end

    // Tail bytes at or above the count belong to an older block and are
    // masked to zero.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_blk_w1[8*i +: 8]  = r_bytes[i];
            o_blk_w2[8*i +: 8]  = r_bytes[8+i];
            o_tail_w1[8*i +: 8] = (mm3_pkg::IDX_W'(i) < i_count) ? r_bytes[i] : 8'd0;
            o_tail_w2[8*i +: 8] = (mm3_pkg::IDX_W'(8 + i) < i_count) ? r_bytes[8+i] : 8'd0;
        end
    end

endmodule

// File: src/murmur3_x64_128_stream_hasher_core.sv
// ============================================================================
// murmur3_x64_128_stream_hasher_core
// Streaming MurmurHash3 x64_128 with seed 0, one message byte per beat.
// ============================================================================
// Sequencing: an absorb beat of a partial block leaves the sequencer idle; the
// sixteenth byte of a block adds a block mix of four 64-bit multiplies. A finish
// beat delivers its digest after four to eight 64-bit multiplies, all run on the
// one shared 32 x 32 multiplier.
// Throughput: one beat at a time; the input stalls while the sequencer runs.
// Reset (synchronous, active low) clears the lanes, the counts and the output valid flag.
// ============================================================================
module murmur3_x64_128_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_digest_hi,
    output logic [63:0] o_digest_lo
);

    // Sequencer state and the hash state proper.
    mm3_pkg::t_state r_state, n_state;
    logic [63:0] r_lane_a, n_lane_a;
    logic [63:0] r_lane_b, n_lane_b;
    logic [mm3_pkg::IDX_W-1:0] r_count, n_count;
    logic [63:0] r_total, n_total;

    // Working registers: r_k carries a scrambled word between multiplies,
    // r_h1 and r_h2 are the finish-time copies of the lanes.
    logic [63:0] r_k, n_k;
    logic [63:0] r_h1, n_h1;
    logic [63:0] r_h2, n_h2;

    // Multiplier handshake bookkeeping.
    logic r_issued, n_issued;

    // Output register. It parts the result from the input side, so a new
    // beat can be taken while a digest still waits.
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_dig_hi, n_dig_hi;
    logic [63:0] r_dig_lo, n_dig_lo;

    logic              in_acc;
    logic              mul_state;
    logic              mul_start;
    logic              mul_done;
    logic [63:0]       mul_a;
    logic [63:0]       mul_b;
    logic [63:0]       mul_p;
    mm3_pkg::t_pend_wr pend_wr;
    logic [63:0]       blk_w1, blk_w2, tail_w1, tail_w2;

    // The input is only taken while the sequencer is idle.
    assign o_in_stall = (r_state != mm3_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == mm3_pkg::ST_IDLE);

    // A new byte is written at the current fill position.
    always_comb begin
        pend_wr.en   = in_acc && (i_kind == mm3_pkg::KIND_ABSORB);
        pend_wr.idx  = r_count;
        pend_wr.data = i_data_byte;
    end

    mm3_pend u_pend (
        .i_clk     (i_clk),
        .i_wr      (pend_wr),
        .i_count   (r_count),
        .o_blk_w1  (blk_w1),
        .o_blk_w2  (blk_w2),
        .o_tail_w1 (tail_w1),
        .o_tail_w2 (tail_w2)
    );

    // Operand selection for the shared multiplier. Every multiply state
    // starts the unit once and then waits for its done pulse.
    always_comb begin
        mul_state = 1'b1;
        mul_a     = r_k;
        mul_b     = mm3_pkg::MIX_C1;
        unique case (r_state)
            mm3_pkg::ST_BA_M1: begin
                mul_a = blk_w1;
                mul_b = mm3_pkg::MIX_C1;
            end
            mm3_pkg::ST_BA_M2: mul_b = mm3_pkg::MIX_C2;
            mm3_pkg::ST_BB_M1: begin
                mul_a = blk_w2;
                mul_b = mm3_pkg::MIX_C2;
            end
            mm3_pkg::ST_BB_M2: mul_b = mm3_pkg::MIX_C1;
            mm3_pkg::ST_TB_M1: begin
                mul_a = tail_w2;
                mul_b = mm3_pkg::MIX_C2;
            end
            mm3_pkg::ST_TB_M2: mul_b = mm3_pkg::MIX_C1;
            mm3_pkg::ST_TA_M1: begin
                mul_a = tail_w1;
                mul_b = mm3_pkg::MIX_C1;
            end
            mm3_pkg::ST_TA_M2: mul_b = mm3_pkg::MIX_C2;
            mm3_pkg::ST_F1_M1: begin
                mul_a = mm3_pkg::xsh33(r_h1);
                mul_b = mm3_pkg::FIN_MUL_A;
            end
            mm3_pkg::ST_F1_M2: begin
                mul_a = r_h1;
                mul_b = mm3_pkg::FIN_MUL_B;
            end
            mm3_pkg::ST_F2_M1: begin
                mul_a = mm3_pkg::xsh33(r_h2);
                mul_b = mm3_pkg::FIN_MUL_A;
            end
            mm3_pkg::ST_F2_M2: begin
                mul_a = r_h2;
                mul_b = mm3_pkg::FIN_MUL_B;
            end
            default: mul_state = 1'b0;
        endcase
    end

    assign mul_start = mul_state && !r_issued;

    mm3_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // Next state and datapath updates of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_lane_a    = r_lane_a;
        n_lane_b    = r_lane_b;
        n_count     = r_count;
        n_total     = r_total;
        n_k         = r_k;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_dig_hi    = r_dig_hi;
        n_dig_lo    = r_dig_lo;
        n_out_valid = r_out_valid && i_out_stall;
        n_issued    = r_issued;

        if (mul_start) begin
            n_issued = 1'b1;
        end
        if (mul_done) begin
            n_issued = 1'b0;
        end

        unique case (r_state)
            mm3_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_kind)
                        mm3_pkg::KIND_ABSORB: begin
                            n_total = r_total + 64'd1;
                            n_count = r_count + mm3_pkg::IDX_W'(1);
                            // The sixteenth byte completes a block; the
                            // count wraps to zero as the mix begins.
                            if (r_count == mm3_pkg::IDX_W'(mm3_pkg::BLOCK_BYTES - 1)) begin
                                n_state = mm3_pkg::ST_BA_M1;
                            end
                        end
                        mm3_pkg::KIND_FINISH: begin
                            n_h1 = r_lane_a;
                            n_h2 = r_lane_b;
                            if (r_count > mm3_pkg::IDX_W'(8)) begin
                                n_state = mm3_pkg::ST_TB_M1;
                            end else if (r_count != '0) begin
                                n_state = mm3_pkg::ST_TA_M1;
                            end else begin
                                n_state = mm3_pkg::ST_FX;
                            end
                        end
                        mm3_pkg::KIND_RESTART: begin
                            n_lane_a = 64'd0;
                            n_lane_b = 64'd0;
                            n_count  = '0;
                            n_total  = 64'd0;
                        end
                        default: begin
                            // The unused kind is dropped without effect.
                            n_state = mm3_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Block round, first lane.
            mm3_pkg::ST_BA_M1: if (mul_done) begin
                n_k     = mm3_pkg::rotl64(mul_p, 31);
                n_state = mm3_pkg::ST_BA_M2;
            end
            mm3_pkg::ST_BA_M2: if (mul_done) begin
                n_k     = mul_p;
                n_state = mm3_pkg::ST_BA_U1;
            end
            mm3_pkg::ST_BA_U1: begin
                n_lane_a = mm3_pkg::rotl64(r_lane_a ^ r_k, 27) + r_lane_b;
                n_state  = mm3_pkg::ST_BA_U2;
            end
            mm3_pkg::ST_BA_U2: begin
                n_lane_a = (r_lane_a << 2) + r_lane_a + mm3_pkg::ROUND_ADD_A;
                n_state  = mm3_pkg::ST_BB_M1;
            end

            // Block round, second lane.
            mm3_pkg::ST_BB_M1: if (mul_done) begin
                n_k     = mm3_pkg::rotl64(mul_p, 33);
                n_state = mm3_pkg::ST_BB_M2;
            end
            mm3_pkg::ST_BB_M2: if (mul_done) begin
                n_k     = mul_p;
                n_state = mm3_pkg::ST_BB_U1;
            end
            mm3_pkg::ST_BB_U1: begin
                n_lane_b = mm3_pkg::rotl64(r_lane_b ^ r_k, 31) + r_lane_a;
                n_state  = mm3_pkg::ST_BB_U2;
            end
            mm3_pkg::ST_BB_U2: begin
                n_lane_b = (r_lane_b << 2) + r_lane_b + mm3_pkg::ROUND_ADD_B;
                n_state  = mm3_pkg::ST_IDLE;
            end

            // Tail mix of the upper tail word, when there is one, then the lower one.
            mm3_pkg::ST_TB_M1: if (mul_done) begin
                n_k     = mm3_pkg::rotl64(mul_p, 33);
                n_state = mm3_pkg::ST_TB_M2;
            end
            mm3_pkg::ST_TB_M2: if (mul_done) begin
                n_h2    = r_h2 ^ mul_p;
                n_state = mm3_pkg::ST_TA_M1;
            end
            mm3_pkg::ST_TA_M1: if (mul_done) begin
                n_k     = mm3_pkg::rotl64(mul_p, 31);
                n_state = mm3_pkg::ST_TA_M2;
            end
            mm3_pkg::ST_TA_M2: if (mul_done) begin
                n_h1    = r_h1 ^ mul_p;
                n_state = mm3_pkg::ST_FX;
            end

            // Length xor and the first cross add.
            mm3_pkg::ST_FX: begin
                n_h1    = (r_h1 ^ r_total) + (r_h2 ^ r_total);
                n_h2    = r_h2 ^ r_total;
                n_state = mm3_pkg::ST_FY;
            end
            mm3_pkg::ST_FY: begin
                n_h2    = r_h2 + r_h1;
                n_state = mm3_pkg::ST_F1_M1;
            end

            // Finalizer on both lanes; the leading xor-shift feeds the
            // multiplier operand directly.
            mm3_pkg::ST_F1_M1: if (mul_done) begin
                n_h1    = mm3_pkg::xsh33(mul_p);
                n_state = mm3_pkg::ST_F1_M2;
            end
            mm3_pkg::ST_F1_M2: if (mul_done) begin
                n_h1    = mm3_pkg::xsh33(mul_p);
                n_state = mm3_pkg::ST_F2_M1;
            end
            mm3_pkg::ST_F2_M1: if (mul_done) begin
                n_h2    = mm3_pkg::xsh33(mul_p);
                n_state = mm3_pkg::ST_F2_M2;
            end
            mm3_pkg::ST_F2_M2: if (mul_done) begin
                n_h2    = mm3_pkg::xsh33(mul_p);
                n_state = mm3_pkg::ST_FZ;
            end

            mm3_pkg::ST_FZ: begin
                n_h1    = r_h1 + r_h2;
                n_state = mm3_pkg::ST_FW;
            end

            // The last add goes straight into the output register, once a
            // digest still waiting there has been taken.
            mm3_pkg::ST_FW: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_dig_hi    = r_h1;
                    n_dig_lo    = r_h2 + r_h1;
                    n_out_valid = 1'b1;
                    n_state     = mm3_pkg::ST_IDLE;
                end
            end

            default: n_state = mm3_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm3_pkg::ST_IDLE;
            r_lane_a    <= 64'd0;
            r_lane_b    <= 64'd0;
            r_count     <= '0;
            r_total     <= 64'd0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane_a    <= n_lane_a;
            r_lane_b    <= n_lane_b;
            r_count     <= n_count;
            r_total     <= n_total;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_h1     <= n_h1;
        r_h2     <= n_h2;
        r_dig_hi <= n_dig_hi;
        r_dig_lo <= n_dig_lo;
    end

    assign o_out_valid = r_out_valid;
    assign o_digest_hi = r_dig_hi;
    assign o_digest_lo = r_dig_lo;

endmodule
